@@ hw/rtl/mavg_pkg.sv @@
// shared types, constants and control structs for the nine axis moving average
package mavg_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int CHANNELS    = 9;
    localparam int CFG_W       = 9;

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int EXT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
        logic signed [SAMPLE_BITS-1:0] mag_x;
        logic signed [SAMPLE_BITS-1:0] mag_y;
        logic signed [SAMPLE_BITS-1:0] mag_z;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_accel_x;
        logic signed [SAMPLE_BITS-1:0] mean_accel_y;
        logic signed [SAMPLE_BITS-1:0] mean_accel_z;
        logic signed [SAMPLE_BITS-1:0] mean_gyro_x;
        logic signed [SAMPLE_BITS-1:0] mean_gyro_y;
        logic signed [SAMPLE_BITS-1:0] mean_gyro_z;
        logic signed [SAMPLE_BITS-1:0] mean_mag_x;
        logic signed [SAMPLE_BITS-1:0] mean_mag_y;
        logic signed [SAMPLE_BITS-1:0] mean_mag_z;
    } out_item_t;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lanes_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic cfg_write;
        logic update;
        logic div_load;
        logic div_step;
        logic load_out;
    } mavg_cmd_t;

    typedef struct packed {
        logic pass;
    } mavg_status_t;

endpackage

@@ hw/rtl/mavg_ctrl.sv @@
// controller state machine: sequences read, sum update, division and output load
module mavg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    output logic                   mean_valid,
    input  logic                   mean_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  mavg_pkg::mavg_status_t status,
    output mavg_pkg::mavg_cmd_t    cmd
);
    import mavg_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free   = !out_valid_reg || !mean_stall;
    assign mean_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = status.pass ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        cfg_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall  = 1'b0;
                cfg_ready     = 1'b1;
                cmd.take      = sample_valid;
                cmd.cfg_write = cfg_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!mean_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    a_take_goes_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !status.pass) |=> (state_reg == ST_READ))
        else $error("filtered item did not start with a store read");

    a_div_runs_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && $past(state_reg) == ST_DIV)
        |-> ($past(step_reg) == STEP_W'(SUM_W - 1)))
        else $error("division left before all quotient bits");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> mean_valid)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !mean_stall))
        else $error("output register overwritten while stalled");

endmodule

@@ hw/rtl/mavg_datapath.sv @@
// datapath: sample ring memory, running sums, nine-lane serial divider, output register
module mavg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mavg_pkg::mavg_cmd_t           cmd,
    output mavg_pkg::mavg_status_t        status,
    input  mavg_pkg::in_item_t            sample,
    input  logic [mavg_pkg::CFG_W-1:0]    window_size,
    output mavg_pkg::out_item_t           mean
);
    import mavg_pkg::*;

    logic [CFG_W-1:0]        win_reg;
    logic [ADDR_W-1:0]       slot_reg, slot_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0] sum_next [CHANNELS];
    lanes_t                  samp_reg;
    lanes_t                  rd_reg;
    lanes_t                  mem [MAX_WINDOW];
    logic [SUM_W-1:0]        dvd_reg  [CHANNELS];
    logic [SUM_W-1:0]        dvd_next [CHANNELS];
    logic [CNT_W-1:0]        rem_reg  [CHANNELS];
    logic [CNT_W-1:0]        rem_next [CHANNELS];
    logic [SUM_W-1:0]        mag      [CHANNELS];
    logic [CHANNELS-1:0]     neg_reg;
    lanes_t                  mean_reg, mean_next;

    logic [CNT_W-1:0]        w_eff;
    logic [ADDR_W-1:0]       rd_addr;
    logic [CNT_W-1:0]        slot_inc;
    logic                    full;

    // oversized window acts as the maximum
    assign w_eff = (EXT_W'(win_reg) > EXT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                          : CNT_W'(win_reg);
    assign status.pass = (w_eff == '0);

    assign rd_addr   = (CNT_W'(slot_reg) < w_eff) ? slot_reg : '0;
    assign slot_inc  = CNT_W'(rd_addr) + CNT_W'(1);
    assign slot_next = (slot_inc == w_eff) ? '0 : slot_inc[ADDR_W-1:0];
    // slots are filled in order, so the slot read holds data only once full
    assign full      = (fill_reg == w_eff);
    assign fill_next = full ? fill_reg : fill_reg + CNT_W'(1);

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [SAMPLE_BITS-1:0] old_s;
            old_s = full ? rd_reg[c] : '0;
            sum_next[c] = sum_reg[c] - SUM_W'($signed(old_s))
                                     + SUM_W'($signed(samp_reg[c]));
            mag[c] = sum_reg[c][SUM_W-1] ? SUM_W'(-sum_reg[c]) : SUM_W'(sum_reg[c]);
        end
    end

    // one restoring division step per lane
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [CNT_W:0]   trial;
            logic [CNT_W+1:0] diff;
            trial = {rem_reg[c], dvd_reg[c][SUM_W-1]};
            diff  = {1'b0, trial} - {2'b00, fill_reg};
            if (!diff[CNT_W+1])
            begin
                rem_next[c] = diff[CNT_W-1:0];
                dvd_next[c] = {dvd_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[CNT_W-1:0];
                dvd_next[c] = {dvd_reg[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [SAMPLE_BITS-1:0] q;
            q = dvd_reg[c][SAMPLE_BITS-1:0];
            if (status.pass)
            begin
                mean_next[c] = samp_reg[c];
            end
            else
            begin
                mean_next[c] = neg_reg[c] ? -q : q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (cmd.cfg_write)
        begin
            win_reg  <= window_size;
            slot_reg <= '0;
            fill_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (cmd.update)
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            samp_reg <= sample;
        end
        if (cmd.div_load)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                dvd_reg[c] <= mag[c];
                rem_reg[c] <= '0;
                neg_reg[c] <= sum_reg[c][SUM_W-1];
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                dvd_reg[c] <= dvd_next[c];
                rem_reg[c] <= rem_next[c];
            end
        end
        if (cmd.load_out)
        begin
            mean_reg <= mean_next;
        end
    end

    // sample ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[rd_addr] <= samp_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    assign mean = mean_reg;

    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= w_eff)
        else $error("fill count beyond window");

    a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (w_eff != '0) |-> (CNT_W'(slot_reg) < w_eff))
        else $error("write slot beyond window");

    a_full_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && full) |=> (fill_reg == $past(fill_reg)))
        else $error("fill count moved on a full window");

endmodule

@@ hw/rtl/nine_axis_moving_average_core.sv @@
// top level of the nine axis moving average: controller and datapath
// filtered item: after accept it passes read, update, divider load, divider steps and finish;
// the next item waits until it is done; the 24-step serial divider runs nine lanes, one quotient bit per cycle
// pass-through (window zero): the item skips read, update and divider; the next waits for its output load
// rst_n clears window, sums, write slot and fill count; a window write loads the window, clears the rest
// the sample memory is not cleared: slots count as empty until written after a clear
module nine_axis_moving_average_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  mavg_pkg::in_item_t           sample,
    output logic                         mean_valid,
    input  logic                         mean_stall,
    output mavg_pkg::out_item_t          mean,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mavg_pkg::CFG_W-1:0]   window_size
);
    import mavg_pkg::*;

    mavg_cmd_t    cmd;
    mavg_status_t status;

    mavg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .mean_valid   (mean_valid),
        .mean_stall   (mean_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mavg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (sample),
        .window_size (window_size),
        .mean        (mean)
    );

endmodule
